// ===== sv/rlrm_pkg.sv =====
// ----------------------------------------------------------------------------
// rlrm_pkg
// Shared widths, status codes, state type and structs of the region moment
// accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlrm_pkg;

    // field widths of one run and of one result
    localparam int LABEL_W  = 8;
    localparam int COORD_W  = 12;
    localparam int STATUS_W = 2;
    localparam int AREA_W   = 25;
    localparam int SX_W     = 36;
    localparam int SY_W     = 36;
    localparam int SXX_W    = 52;
    localparam int SXY_W    = 48;
    localparam int SYY_W    = 52;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 264;

    // widths of one run's increments at full coordinate width
    localparam int INC_N_W   = COORD_W + 1;
    localparam int INC_SX_W  = 2 * COORD_W + 1;
    localparam int INC_NY_W  = 2 * COORD_W + 1;
    localparam int INC_SXX_W = 3 * COORD_W + 3;
    localparam int INC_SXY_W = 3 * COORD_W + 1;
    localparam int INC_SYY_W = 3 * COORD_W + 5;

    localparam logic [STATUS_W-1:0] ST_UPDATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_ACC
    } t_state;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [SX_W-1:0]   sum_x;
        logic [SY_W-1:0]   sum_y;
        logic [SXX_W-1:0]  sum_xx;
        logic [SXY_W-1:0]  sum_xy;
        logic [SYY_W-1:0]  sum_yy;
    } t_sums;

    typedef struct packed {
        logic [INC_N_W-1:0]   n;
        logic [INC_SX_W-1:0]  sx;
        logic [INC_NY_W-1:0]  ny;
        logic [INC_SXX_W-1:0] sxx12;
        logic [INC_SXY_W-1:0] sxy;
        logic [INC_SYY_W-1:0] syy12;
    } t_terms;

endpackage

// ===== sv/rlrm_terms.sv =====
// ----------------------------------------------------------------------------
// rlrm_terms
// Three-stage product pipeline that forms one run's moment increments from
// its row and first and last column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlrm_terms #(
    parameter int CW = 12
) (
    input  logic                   i_clk,
    input  logic [CW-1:0]          i_row,
    input  logic [CW-1:0]          i_start,
    input  logic [CW-1:0]          i_end,
    output rlrm_pkg::t_terms       o_terms
);

    localparam int NW   = rlrm_pkg::INC_N_W;
    localparam int SXW  = rlrm_pkg::INC_SX_W;
    localparam int NYW  = rlrm_pkg::INC_NY_W;
    localparam int SXXW = rlrm_pkg::INC_SXX_W;
    localparam int SXYW = rlrm_pkg::INC_SXY_W;
    localparam int SYYW = rlrm_pkg::INC_SYY_W;

    // stage 1
    logic [CW:0]     w_n;
    logic [CW:0]     w_s;
    logic [CW:0]     w_b1;
    logic [CW-1:0]   w_am1;
    logic [2*CW+1:0] w_ns;
    logic [2*CW:0]   w_ny;
    logic [2*CW-1:0] w_y2;
    logic [2*CW:0]   w_pb;
    logic [2*CW-1:0] w_pa;

    logic [CW:0]     r1_n;
    logic [CW-1:0]   r1_a;
    logic [CW-1:0]   r1_b;
    logic [CW-1:0]   r1_y;
    logic [2*CW:0]   r1_sx;
    logic [2*CW:0]   r1_ny;
    logic [2*CW-1:0] r1_y2;
    logic [2*CW:0]   r1_pb;
    logic [2*CW-1:0] r1_pa;

    // stage 2
    logic [CW:0]     w_b2p1;
    logic [CW:0]     w_a2m1;
    logic [3*CW+1:0] w_sb;
    logic [3*CW:0]   w_sa;
    logic [3*CW:0]   w_sxy;
    logic [2*CW+3:0] w_yy12;

    logic [CW:0]     r2_n;
    logic [2*CW:0]   r2_sx;
    logic [2*CW:0]   r2_ny;
    logic [3*CW+1:0] r2_sb;
    logic [3*CW+1:0] r2_sa;
    logic [3*CW:0]   r2_sxy;
    logic [2*CW+3:0] r2_yy12;

    // stage 3
    logic [3*CW+1:0] w_sdiff;
    logic [3*CW+2:0] w_sxx12;
    logic [3*CW+4:0] w_syy12;

    logic [CW:0]     r3_n;
    logic [2*CW:0]   r3_sx;
    logic [2*CW:0]   r3_ny;
    logic [3*CW+2:0] r3_sxx12;
    logic [3*CW:0]   r3_sxy;
    logic [3*CW+4:0] r3_syy12;

    always_comb begin
        w_n   = {1'b0, i_end} - {1'b0, i_start} + (CW+1)'(1);
        w_s   = {1'b0, i_start} + {1'b0, i_end};
        w_b1  = {1'b0, i_end} + (CW+1)'(1);
        w_am1 = i_start - CW'(1);
        w_ns  = (2*CW+2)'(w_n) * (2*CW+2)'(w_s);
        w_ny  = (2*CW+1)'(w_n) * (2*CW+1)'(i_row);
        w_y2  = (2*CW)'(i_row) * (2*CW)'(i_row);
        w_pb  = (2*CW+1)'(i_end) * (2*CW+1)'(w_b1);
        w_pa  = (2*CW)'(i_start) * (2*CW)'(w_am1);
    end

    always_ff @(posedge i_clk) begin
        r1_n  <= w_n;
        r1_a  <= i_start;
        r1_b  <= i_end;
        r1_y  <= i_row;
        r1_sx <= w_ns[2*CW+1:1];
        r1_ny <= w_ny;
        r1_y2 <= w_y2;
        r1_pb <= w_pb;
        r1_pa <= w_pa;
    end

    always_comb begin
        w_b2p1 = {r1_b, 1'b1};
        w_a2m1 = {r1_a, 1'b0} - (CW+1)'(1);
        w_sb   = (3*CW+2)'(r1_pb) * (3*CW+2)'(w_b2p1);
        w_sa   = (3*CW+1)'(r1_pa) * (3*CW+1)'(w_a2m1);
        w_sxy  = (3*CW+1)'(r1_sx) * (3*CW+1)'(r1_y);
        w_yy12 = ((2*CW+4)'(r1_y2) << 3) + ((2*CW+4)'(r1_y2) << 2) + (2*CW+4)'(1);
    end

    always_ff @(posedge i_clk) begin
        r2_n    <= r1_n;
        r2_sx   <= r1_sx;
        r2_ny   <= r1_ny;
        r2_sb   <= w_sb;
        r2_sa   <= (3*CW+2)'(w_sa);
        r2_sxy  <= w_sxy;
        r2_yy12 <= w_yy12;
    end

    always_comb begin
        w_sdiff = r2_sb - r2_sa;
        w_sxx12 = {w_sdiff, 1'b0} + (3*CW+3)'(r2_n);
        w_syy12 = (3*CW+5)'(r2_n) * (3*CW+5)'(r2_yy12);
    end

    always_ff @(posedge i_clk) begin
        r3_n     <= r2_n;
        r3_sx    <= r2_sx;
        r3_ny    <= r2_ny;
        r3_sxx12 <= w_sxx12;
        r3_sxy   <= r2_sxy;
        r3_syy12 <= w_syy12;
    end

    always_comb begin
        o_terms.n     = NW'(r3_n);
        o_terms.sx    = SXW'(r3_sx);
        o_terms.ny    = NYW'(r3_ny);
        o_terms.sxx12 = SXXW'(r3_sxx12);
        o_terms.sxy   = SXYW'(r3_sxy);
        o_terms.syy12 = SYYW'(r3_syy12);
    end

endmodule

// ===== sv/run_length_region_moments.sv =====
// ----------------------------------------------------------------------------
// run_length_region_moments
// Takes one horizontal run (label, row, first and last column) and adds its
// area, first moments and second moments (in twelfths, with the pixel area
// term) to the region's entry in a sum store, returning the updated totals.
// A label equal to the region count opens a new entry; a label above the
// count or beyond the store, or a run whose end lies before its start, is
// returned with status ignored and zero totals and leaves the store alone.
// Totals saturate at the all-ones value of their field. A run is taken while
// the block is idle; it passes through the product pipeline while the
// region's entry is read from the single-port sum store, and then the entry
// is added to with saturation and written back. No new run is taken before
// that write-back; the next run can be taken in the cycle after it, and the
// write-back waits while an earlier result still waits on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module run_length_region_moments #(
    parameter int MAX_REGIONS = 256,
    parameter int COORD_BITS  = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // region_label, row, run_start, run_end, zero fill
    input  logic [rlrm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_region, area, sum_x, sum_y, sum_xx_twelfths, sum_xy,
    // sum_yy_twelfths, zero fill
    output logic [rlrm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status
    output logic [rlrm_pkg::STATUS_W-1:0]       m_axis_tuser
);

    localparam int LW   = rlrm_pkg::LABEL_W;
    localparam int FW   = rlrm_pkg::COORD_W;
    localparam int CW   = (COORD_BITS < FW) ? COORD_BITS : FW;
    localparam int IW   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int RCW  = $clog2(MAX_REGIONS + 1);
    localparam int AW   = rlrm_pkg::AREA_W;
    localparam int SXW  = rlrm_pkg::SX_W;
    localparam int SYW  = rlrm_pkg::SY_W;
    localparam int SXXW = rlrm_pkg::SXX_W;
    localparam int SXYW = rlrm_pkg::SXY_W;
    localparam int SYYW = rlrm_pkg::SYY_W;
    localparam int PADW = rlrm_pkg::OUT_DATA_W - (LW + AW + SXW + SYW + SXXW + SXYW + SYYW);

    rlrm_pkg::t_state r_state;
    rlrm_pkg::t_state n_state;

    logic [LW-1:0]   r_label;
    logic [CW-1:0]   r_row;
    logic [CW-1:0]   r_start;
    logic [CW-1:0]   r_end;
    logic [RCW-1:0]  r_count;
    logic            r_bad;
    logic            r_new;

    rlrm_pkg::t_sums r_mem [MAX_REGIONS];
    rlrm_pkg::t_sums r_rd;
    rlrm_pkg::t_sums w_acc;
    rlrm_pkg::t_sums n_sums;
    rlrm_pkg::t_terms w_terms;

    logic            r_m_valid;
    logic [rlrm_pkg::OUT_DATA_W-1:0] r_m_data;
    logic [rlrm_pkg::STATUS_W-1:0]   r_m_user;

    logic            w_accept;
    logic            w_rd_en;
    logic            w_fire;
    logic            w_wr_en;
    logic [31:0]     w_label32;
    logic [31:0]     w_count32;
    logic [IW-1:0]   w_idx;
    logic            w_bad;
    logic            w_new;

    logic [AW:0]     w_area_sum;
    logic [SXW:0]    w_sx_sum;
    logic [SYW:0]    w_sy_sum;
    logic [SXXW:0]   w_sxx_sum;
    logic [SXYW:0]   w_sxy_sum;
    logic [SYYW:0]   w_syy_sum;

    rlrm_terms #(
        .CW (CW)
    ) u_terms (
        .i_clk   (i_clk),
        .i_row   (r_row),
        .i_start (r_start),
        .i_end   (r_end),
        .o_terms (w_terms)
    );

    assign s_axis_tready = i_rst_n && (r_state == rlrm_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_label32 = 32'(r_label);
    assign w_count32 = 32'(r_count);
    assign w_idx     = w_label32[IW-1:0];
    assign w_bad     = (r_end < r_start) || (w_label32 >= 32'(MAX_REGIONS))
                       || (w_label32 > w_count32);
    assign w_new     = (w_label32 == w_count32);

    // FSM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlrm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_rd_en = 1'b0;
        w_fire  = 1'b0;
        case (r_state)
            rlrm_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = rlrm_pkg::S_MUL1;
                end
            end
            rlrm_pkg::S_MUL1: begin
                w_rd_en = 1'b1;
                n_state = rlrm_pkg::S_MUL2;
            end
            rlrm_pkg::S_MUL2: begin
                n_state = rlrm_pkg::S_MUL3;
            end
            rlrm_pkg::S_MUL3: begin
                n_state = rlrm_pkg::S_ACC;
            end
            rlrm_pkg::S_ACC: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_fire  = 1'b1;
                    n_state = rlrm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rlrm_pkg::S_IDLE;
            end
        endcase
    end

    assign w_wr_en = w_fire && !r_bad;

    // hold the run, reduced to the coordinate width
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_label <= s_axis_tdata[LW-1:0];
            r_row   <= s_axis_tdata[LW +: CW];
            r_start <= s_axis_tdata[LW+FW +: CW];
            r_end   <= s_axis_tdata[LW+2*FW +: CW];
        end
        if (w_rd_en) begin
            r_bad <= w_bad;
            r_new <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_wr_en && r_new) begin
            r_count <= r_count + RCW'(1);
        end
    end

    // sum store
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd <= r_mem[w_idx];
        end
        if (w_wr_en) begin
            r_mem[w_idx] <= n_sums;
        end
    end

    // saturating accumulate
    always_comb begin
        w_acc      = r_new ? '0 : r_rd;
        w_area_sum = {1'b0, w_acc.area}   + (AW+1)'(w_terms.n);
        w_sx_sum   = {1'b0, w_acc.sum_x}  + (SXW+1)'(w_terms.sx);
        w_sy_sum   = {1'b0, w_acc.sum_y}  + (SYW+1)'(w_terms.ny);
        w_sxx_sum  = {1'b0, w_acc.sum_xx} + (SXXW+1)'(w_terms.sxx12);
        w_sxy_sum  = {1'b0, w_acc.sum_xy} + (SXYW+1)'(w_terms.sxy);
        w_syy_sum  = {1'b0, w_acc.sum_yy} + (SYYW+1)'(w_terms.syy12);
        n_sums.area   = w_area_sum[AW]   ? '1 : w_area_sum[AW-1:0];
        n_sums.sum_x  = w_sx_sum[SXW]    ? '1 : w_sx_sum[SXW-1:0];
        n_sums.sum_y  = w_sy_sum[SYW]    ? '1 : w_sy_sum[SYW-1:0];
        n_sums.sum_xx = w_sxx_sum[SXXW]  ? '1 : w_sxx_sum[SXXW-1:0];
        n_sums.sum_xy = w_sxy_sum[SXYW]  ? '1 : w_sxy_sum[SXYW-1:0];
        n_sums.sum_yy = w_syy_sum[SYYW]  ? '1 : w_syy_sum[SYYW-1:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_fire) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (r_bad) begin
                r_m_data <= {{(rlrm_pkg::OUT_DATA_W-LW){1'b0}}, r_label};
                r_m_user <= rlrm_pkg::ST_IGNORED;
            end else begin
                r_m_data <= {{PADW{1'b0}}, n_sums.sum_yy, n_sums.sum_xy, n_sums.sum_xx,
                             n_sums.sum_y, n_sums.sum_x, n_sums.area, r_label};
                r_m_user <= r_new ? rlrm_pkg::ST_NEW : rlrm_pkg::ST_UPDATED;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// ===== sv/rlrm_chk.sv =====
// ----------------------------------------------------------------------------
// rlrm_chk
// Port-level checks of the region moment accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlrm_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [rlrm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic [rlrm_pkg::STATUS_W-1:0]       m_axis_tuser
);

    // one run in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a run is in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == rlrm_pkg::ST_UPDATED
                           || m_axis_tuser == rlrm_pkg::ST_NEW
                           || m_axis_tuser == rlrm_pkg::ST_IGNORED))
        else $error("undefined status on output");

    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == rlrm_pkg::ST_IGNORED)
            |-> (m_axis_tdata[rlrm_pkg::OUT_DATA_W-1:rlrm_pkg::LABEL_W] == '0))
        else $error("ignored run carries non-zero totals");

    a_new_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == rlrm_pkg::ST_NEW)
            |-> (m_axis_tdata[rlrm_pkg::LABEL_W +: rlrm_pkg::AREA_W] != '0))
        else $error("new region with zero area");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind run_length_region_moments rlrm_chk u_rlrm_chk (.*);
